>>> sv/hst_pkg.sv
`timescale 1ns / 1ps

package hst_pkg;

  localparam int GRAINS      = 32;
  localparam int ROWS        = 12;
  localparam int SAND_COLUMN = 4;
  localparam int PILE_CELLS  = 32;

  localparam int COUNT_W  = 6;
  localparam int ROW_W    = 4;
  localparam int STEP_W   = 3;
  localparam int SEL_W    = 8;
  localparam int SPAWN_W  = 17;
  localparam int QUIET_W  = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_DROP_PERIOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 1'd1;

  localparam logic [7:0] DROP_PERIOD_RESET = 8'd40;
  localparam logic [7:0] DEBOUNCE_RESET    = 8'd50;

  localparam logic [STEP_W-1:0] SND_OFF    = 3'd0;
  localparam logic [STEP_W-1:0] SND_FLIP   = 3'd1;
  localparam logic [STEP_W-1:0] SND_BUTTON = 3'd2;
  localparam logic [STEP_W-1:0] SND_BEEP1  = 3'd3;
  localparam logic [STEP_W-1:0] SND_BEEP2  = 3'd4;
  localparam logic [STEP_W-1:0] SND_BEEP3  = 3'd5;

  localparam logic [SEL_W-1:0] FLIP_LEN   = 8'd50;
  localparam logic [SEL_W-1:0] BUTTON_LEN = 8'd100;
  localparam logic [SEL_W-1:0] BEEP_LEN   = 8'd250;
  localparam logic [SEL_W-1:0] BEEP_ON    = 8'd150;

  localparam logic [1:0] TONE_OFF  = 2'd0;
  localparam logic [1:0] TONE_1000 = 2'd1;
  localparam logic [1:0] TONE_1500 = 2'd2;
  localparam logic [1:0] TONE_2000 = 2'd3;

  typedef logic [ROWS-1:0][7:0] rows_t;

  typedef struct packed {
    logic [COUNT_W-1:0] top_count;
    logic [COUNT_W-1:0] bottom_count;
    logic               grain_active;
    logic [ROW_W-1:0]   grain_row;
    logic               flipped;
    logic [STEP_W-1:0]  sound_step;
    logic [SEL_W-1:0]   sound_elapsed;
  } hst_state_t;

  localparam logic [7:0] TOP_ORDER [PILE_CELLS] = '{
    8'h54, 8'h45, 8'h43, 8'h36, 8'h32, 8'h27, 8'h21, 8'h10,
    8'h44, 8'h35, 8'h33, 8'h26, 8'h22, 8'h17, 8'h11, 8'h00,
    8'h34, 8'h25, 8'h23, 8'h16, 8'h12, 8'h07, 8'h01, 8'h24,
    8'h15, 8'h13, 8'h06, 8'h02, 8'h14, 8'h05, 8'h03, 8'h04
  };

  localparam logic [7:0] BOTTOM_ORDER [PILE_CELLS] = '{
    8'hB4, 8'hB3, 8'hB5, 8'hA4, 8'hB2, 8'hB6, 8'hA3, 8'hA5,
    8'h94, 8'hB1, 8'hB7, 8'hA2, 8'hA6, 8'h93, 8'h95, 8'h84,
    8'hB0, 8'hA1, 8'hA7, 8'h92, 8'h96, 8'h83, 8'h85, 8'h74,
    8'hA0, 8'h91, 8'h97, 8'h82, 8'h86, 8'h73, 8'h75, 8'h64
  };

  // both piles drawn as thermometers over their fill orders
  function automatic rows_t pile_rows(input logic [COUNT_W-1:0] top,
                                      input logic [COUNT_W-1:0] bottom);
    rows_t rows;
    rows = '0;
    for (int i = 0; i < PILE_CELLS; i++) begin
      if (COUNT_W'(i) < top) begin
        rows[TOP_ORDER[i][7:4]][TOP_ORDER[i][2:0]] = 1'b1;
      end
      if (COUNT_W'(i) < bottom) begin
        rows[BOTTOM_ORDER[i][7:4]][BOTTOM_ORDER[i][2:0]] = 1'b1;
      end
    end
    return rows;
  endfunction

endpackage

>>> sv/hst_engine.sv
`timescale 1ns / 1ps

module hst_engine (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  tilt_level,
  input  logic                  button_level,
  input  logic [9:0]            pot_value,
  input  logic [7:0]            drop_period_ms,
  input  logic [7:0]            debounce_ms,
  output hst_pkg::hst_state_t   state_next
);
  import hst_pkg::*;

  hst_state_t         st;
  logic               last_tilt, last_tilt_next;
  logic [QUIET_W-1:0] tilt_quiet_ms, tilt_quiet_ms_next;
  logic               last_button, last_button_next;
  logic [SPAWN_W-1:0] spawn_period, spawn_period_next;
  logic [SPAWN_W-1:0] spawn_elapsed, spawn_elapsed_next;
  logic [7:0]         fall_elapsed, fall_elapsed_next;
  logic               alarm_done, alarm_done_next;

  logic [SEL_W-1:0]   snd_len;
  logic [SEL_W-1:0]   snd_inc;
  logic [SPAWN_W-1:0] spawn_inc;
  logic [ROW_W-1:0]   row_step;
  logic [ROW_W-1:0]   row_below;
  logic               landed;
  logic               want_flip;
  rows_t              sand;

  function automatic logic [SPAWN_W-1:0] zone_period(input logic [9:0] pot);
    logic [SPAWN_W-1:0] p;
    if (pot < 10'd146)      p = 17'd937;
    else if (pot < 10'd292) p = 17'd1875;
    else if (pot < 10'd438) p = 17'd3750;
    else if (pot < 10'd585) p = 17'd28125;
    else if (pot < 10'd731) p = 17'd56250;
    else if (pot < 10'd877) p = 17'd84375;
    else                    p = 17'd112500;
    return p;
  endfunction

  always_comb begin
    case (st.sound_step)
      SND_FLIP:   snd_len = FLIP_LEN;
      SND_BUTTON: snd_len = BUTTON_LEN;
      default:    snd_len = BEEP_LEN;
    endcase
    snd_inc   = st.sound_elapsed + 8'd1;
    spawn_inc = (spawn_elapsed == {SPAWN_W{1'b1}}) ? spawn_elapsed : spawn_elapsed + 17'd1;
    row_step  = st.grain_row + 4'd1;
    row_below = row_step + 4'd1;
    sand      = pile_rows(st.top_count, st.bottom_count);
    if (row_step >= ROW_W'(ROWS - 1)) landed = 1'b1;
    else                              landed = sand[row_below][SAND_COLUMN];

    state_next         = st;
    last_tilt_next     = last_tilt;
    tilt_quiet_ms_next = tilt_quiet_ms;
    last_button_next   = last_button;
    spawn_period_next  = spawn_period;
    spawn_elapsed_next = spawn_elapsed;
    fall_elapsed_next  = fall_elapsed;
    alarm_done_next    = alarm_done;
    want_flip          = 1'b0;

    // sound playback
    if (st.sound_step != SND_OFF) begin
      if (st.sound_step > SND_BEEP3) begin
        state_next.sound_step    = SND_OFF;
        state_next.sound_elapsed = '0;
      end else if (snd_inc >= snd_len) begin
        state_next.sound_elapsed = '0;
        if (st.sound_step inside {SND_BEEP1, SND_BEEP2}) begin
          state_next.sound_step = st.sound_step + 3'd1;
        end else begin
          state_next.sound_step = SND_OFF;
        end
      end else begin
        state_next.sound_elapsed = snd_inc;
      end
    end

    if (state_next.sound_step == SND_OFF) begin
      if (tilt_level != last_tilt) tilt_quiet_ms_next = '0;
      else if (tilt_quiet_ms != {QUIET_W{1'b1}}) tilt_quiet_ms_next = tilt_quiet_ms + 16'd1;
      last_tilt_next = tilt_level;
      want_flip = (tilt_quiet_ms_next > {8'd0, debounce_ms}) && (!tilt_level != st.flipped);

      if (want_flip) begin
        state_next.flipped       = !tilt_level;
        state_next.top_count     = st.bottom_count;
        state_next.bottom_count  = st.top_count;
        state_next.grain_active  = 1'b0;
        alarm_done_next          = 1'b0;
        spawn_elapsed_next       = '0;
        state_next.sound_step    = SND_FLIP;
        state_next.sound_elapsed = '0;
      end else if (last_button && !button_level) begin
        last_button_next         = 1'b0;
        spawn_period_next        = zone_period(pot_value);
        state_next.top_count     = COUNT_W'(GRAINS);
        state_next.bottom_count  = '0;
        state_next.grain_active  = 1'b0;
        alarm_done_next          = 1'b0;
        spawn_elapsed_next       = '0;
        state_next.sound_step    = SND_BUTTON;
        state_next.sound_elapsed = '0;
      end else begin
        last_button_next   = button_level;
        spawn_elapsed_next = spawn_inc;
        if (!st.grain_active) begin
          if (spawn_inc > spawn_period) begin
            spawn_elapsed_next = spawn_inc - spawn_period;
            if (st.top_count != '0) begin
              state_next.top_count    = st.top_count - 6'd1;
              state_next.grain_active = 1'b1;
              state_next.grain_row    = 4'd6;
              fall_elapsed_next       = '0;
            end else if (st.bottom_count == COUNT_W'(GRAINS) && !alarm_done) begin
              alarm_done_next          = 1'b1;
              state_next.sound_step    = SND_BEEP1;
              state_next.sound_elapsed = '0;
            end
          end
        end else if (fall_elapsed >= drop_period_ms) begin
          fall_elapsed_next    = '0;
          state_next.grain_row = row_step;
          if (landed) begin
            if (st.bottom_count != {COUNT_W{1'b1}}) begin
              state_next.bottom_count = st.bottom_count + 6'd1;
            end
            state_next.grain_active = 1'b0;
          end
        end else begin
          fall_elapsed_next = fall_elapsed + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.top_count     <= COUNT_W'(GRAINS);
      st.bottom_count  <= '0;
      st.grain_active  <= 1'b0;
      st.grain_row     <= '0;
      st.flipped       <= 1'b0;
      st.sound_step    <= SND_OFF;
      st.sound_elapsed <= '0;
      last_tilt        <= 1'b0;
      tilt_quiet_ms    <= '0;
      last_button      <= 1'b1;
      spawn_period     <= 17'd1875;
      spawn_elapsed    <= '0;
      fall_elapsed     <= '0;
      alarm_done       <= 1'b0;
    end else if (step) begin
      st            <= state_next;
      last_tilt     <= last_tilt_next;
      tilt_quiet_ms <= tilt_quiet_ms_next;
      last_button   <= last_button_next;
      spawn_period  <= spawn_period_next;
      spawn_elapsed <= spawn_elapsed_next;
      fall_elapsed  <= fall_elapsed_next;
      alarm_done    <= alarm_done_next;
    end
  end

endmodule

>>> sv/hst_render.sv
`timescale 1ns / 1ps

module hst_render (
  input  hst_pkg::hst_state_t st,
  output logic [47:0]         frame_upper,
  output logic [47:0]         frame_lower,
  output logic [1:0]          tone_code
);
  import hst_pkg::*;

  rows_t rows;
  rows_t disp;

  always_comb begin
    rows = pile_rows(st.top_count, st.bottom_count);
    if (st.grain_active && st.grain_row < ROW_W'(ROWS)) begin
      rows[st.grain_row][SAND_COLUMN] = 1'b1;
    end
    for (int r = 0; r < ROWS; r++) begin
      disp[r] = st.flipped ? rows[ROWS-1-r] : rows[r];
    end
    frame_upper = disp[5:0];
    frame_lower = disp[11:6];

    case (st.sound_step)
      SND_FLIP:   tone_code = TONE_1000;
      SND_BUTTON: tone_code = TONE_1500;
      SND_BEEP1, SND_BEEP2, SND_BEEP3:
        tone_code = (st.sound_elapsed < BEEP_ON) ? TONE_2000 : TONE_OFF;
      default:    tone_code = TONE_OFF;
    endcase
  end

endmodule

>>> sv/hourglass_sand_timer_unit.sv
`timescale 1ns / 1ps
// channel  handshake             word
// in       in_valid / in_stall   tilt_level, button_level, pot_value
// out      out_valid / out_stall frame_upper, frame_lower, tone_code, is_flipped
// cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One tick word per cycle while the result is not stalled; the result word passes through
// the input register and then the result register around the state update.
// Reset restores the power-on glass and register defaults; nothing to sweep.
// A stalled result holds the whole pipe and raises in_stall in the same cycle.
// cfg_ready is always high.

module hourglass_sand_timer_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           tilt_level,
  input  logic                           button_level,
  input  logic [9:0]                     pot_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [47:0]                    frame_upper,
  output logic [47:0]                    frame_lower,
  output logic [1:0]                     tone_code,
  output logic                           is_flipped,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hst_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                     cfg_data
);
  import hst_pkg::*;

  logic       advance;
  logic       s1_valid;
  logic       s1_tilt;
  logic       s1_button;
  logic [9:0] s1_pot;
  logic [7:0] drop_period_ms;
  logic [7:0] debounce_ms;

  hst_state_t  state_next;
  logic [47:0] frame_upper_next;
  logic [47:0] frame_lower_next;
  logic [1:0]  tone_code_next;

  assign advance   = !(out_valid && out_stall);
  assign in_stall  = !advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      drop_period_ms <= DROP_PERIOD_RESET;
      debounce_ms    <= DEBOUNCE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DROP_PERIOD: drop_period_ms <= cfg_data;
        REG_DEBOUNCE:    debounce_ms    <= cfg_data;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      s1_tilt   <= tilt_level;
      s1_button <= button_level;
      s1_pot    <= pot_value;
    end
  end

  hst_engine u_engine (
    .clk            (clk),
    .rst            (rst),
    .step           (advance && s1_valid),
    .tilt_level     (s1_tilt),
    .button_level   (s1_button),
    .pot_value      (s1_pot),
    .drop_period_ms (drop_period_ms),
    .debounce_ms    (debounce_ms),
    .state_next     (state_next)
  );

  hst_render u_render (
    .st          (state_next),
    .frame_upper (frame_upper_next),
    .frame_lower (frame_lower_next),
    .tone_code   (tone_code_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      frame_upper <= frame_upper_next;
      frame_lower <= frame_lower_next;
      tone_code   <= tone_code_next;
      is_flipped  <= state_next.flipped;
    end
  end

endmodule
